FILE: rtl/core/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants for the frame reorder buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

  localparam int STORE_DEPTH_DEF  = 16;
  localparam int HANDLE_WIDTH_DEF = 16;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 16;
  localparam int CNT_W  = 32;
  localparam int CFG_DW = 11;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_MIN_SEG = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX_SEG = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MIN_BUF = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_HDR     = 2'd3;

  localparam logic [10:0] MIN_SEG_RST = 11'd16;
  localparam logic [10:0] MAX_SEG_RST = 11'd1500;
  localparam logic [10:0] MIN_BUF_RST = 11'd24;
  localparam logic [7:0]  HDR_RST     = 8'd16;

  localparam logic [1:0] CAUSE_IN_ORDER = 2'd0;
  localparam logic [1:0] CAUSE_DRAINED  = 2'd1;
  localparam logic [1:0] CAUSE_FORCED   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_DECIDE,
    ST_GAP,
    ST_FORCE,
    ST_DRAIN,
    ST_DSCAN,
    ST_DHIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SRC_NEW,
    SRC_MEM,
    SRC_HIT
  } emit_src_t;

  typedef struct packed {
    logic       load_in;
    logic       scan_start;
    logic       scan_step;
    logic       rd_min;
    logic       calc_gap;
    logic       add_gap;
    logic       emit;
    emit_src_t  emit_src;
    logic [1:0] emit_cause;
    logic       clear_hit;
    logic       store_new;
    logic       store_at_min;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic bad_len;
    logic first;
    logic stale;
    logic next;
    logic last_max;
    logic scan_last;
    logic dup;
    logic full;
    logic new_lt_min;
    logic hit_found;
    logic emit_ok;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/frame_reorder_buffer.sv
// ----------------------------------------------------------------------------
// frame_reorder_buffer
// Sequence-number reorder buffer for received frame descriptors.
// ----------------------------------------------------------------------------
// One request is handled at a time. A rejected or stale frame goes straight
// back to idle and a first frame is released directly. An in-order frame is
// released and then drains the store. Every store search walks the store one
// entry per cycle through its single read port. An early frame is stored after
// one search unless it is a duplicate. When the store is full, a gap count and
// a forced release follow the search, then the drain. Each frame drained from
// the store takes one search. A drain closes after a search that finds no
// next frame, or without one if the last released sequence is the maximum.
// Releases leave through a pending stage and an output register, so the run
// of an input can stall on out_stall without losing order; such stalls add
// to its run. Config writes are always ready and are meant for idle periods.
// ----------------------------------------------------------------------------
module frame_reorder_buffer #(
  parameter int STORE_DEPTH  = frb_pkg::STORE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = frb_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [frb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [frb_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [frb_pkg::SEQ_W-1:0]  frame_seq,
  input  logic [frb_pkg::LEN_W-1:0]  segment_len,
  input  logic [frb_pkg::LEN_W-1:0]  buffer_len,
  input  logic [HANDLE_WIDTH-1:0]    buffer_handle,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [frb_pkg::SEQ_W-1:0]  out_seq,
  output logic [HANDLE_WIDTH-1:0]    out_handle,
  output logic [frb_pkg::LEN_W-1:0]  payload_len,
  output logic [1:0]                 release_cause,
  output logic                       last_of_run,
  output logic [frb_pkg::CNT_W-1:0]  missed_total,
  output logic [frb_pkg::CNT_W-1:0]  released_total
);

  frb_pkg::cmd_t    cmd;
  frb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  frb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  frb_datapath #(
    .STORE_DEPTH  (STORE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .frame_seq      (frame_seq),
    .segment_len    (segment_len),
    .buffer_len     (buffer_len),
    .buffer_handle  (buffer_handle),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_seq        (out_seq),
    .out_handle     (out_handle),
    .payload_len    (payload_len),
    .release_cause  (release_cause),
    .last_of_run    (last_of_run),
    .missed_total   (missed_total),
    .released_total (released_total),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

FILE: rtl/core/frb_ctrl.sv
// ----------------------------------------------------------------------------
// frb_ctrl
// Sequencer for the reorder buffer: classifies each request, walks the
// store for search and drain, and steps the datapath through releases.
// ----------------------------------------------------------------------------
module frb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  frb_pkg::status_t status,
  output frb_pkg::cmd_t    cmd
);

  frb_pkg::state_t state;
  frb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      frb_pkg::ST_IDLE: begin
        if (in_valid) state_next = frb_pkg::ST_CLASSIFY;
      end
      frb_pkg::ST_CLASSIFY: begin
        if (status.bad_len) begin
          state_next = frb_pkg::ST_IDLE;
        end else if (status.first) begin
          if (status.emit_ok) state_next = frb_pkg::ST_FINISH;
        end else if (status.stale) begin
          state_next = frb_pkg::ST_IDLE;
        end else if (status.next) begin
          if (status.emit_ok) state_next = frb_pkg::ST_DRAIN;
        end else begin
          state_next = frb_pkg::ST_SCAN;
        end
      end
      frb_pkg::ST_SCAN: begin
        if (status.scan_last) state_next = frb_pkg::ST_DECIDE;
      end
      frb_pkg::ST_DECIDE: begin
        if (status.dup || !status.full) begin
          state_next = frb_pkg::ST_IDLE;
        end else begin
          state_next = frb_pkg::ST_GAP;
        end
      end
      frb_pkg::ST_GAP: begin
        state_next = frb_pkg::ST_FORCE;
      end
      frb_pkg::ST_FORCE: begin
        if (status.emit_ok) state_next = frb_pkg::ST_DRAIN;
      end
      frb_pkg::ST_DRAIN: begin
        if (status.last_max) begin
          state_next = frb_pkg::ST_FINISH;
        end else begin
          state_next = frb_pkg::ST_DSCAN;
        end
      end
      frb_pkg::ST_DSCAN: begin
        if (status.scan_last) state_next = frb_pkg::ST_DHIT;
      end
      frb_pkg::ST_DHIT: begin
        if (!status.hit_found) begin
          state_next = frb_pkg::ST_FINISH;
        end else if (status.emit_ok) begin
          state_next = frb_pkg::ST_DRAIN;
        end
      end
      frb_pkg::ST_FINISH: begin
        if (status.out_free) state_next = frb_pkg::ST_IDLE;
      end
      default: begin
        state_next = frb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_src = frb_pkg::SRC_NEW;
    in_stall     = (state != frb_pkg::ST_IDLE);
    unique case (state)
      frb_pkg::ST_IDLE: begin
        cmd.load_in = in_valid;
      end
      frb_pkg::ST_CLASSIFY: begin
        if (!status.bad_len) begin
          if (status.first || (!status.stale && status.next)) begin
            cmd.emit       = status.emit_ok;
            cmd.emit_src   = frb_pkg::SRC_NEW;
            cmd.emit_cause = frb_pkg::CAUSE_IN_ORDER;
          end else if (!status.stale) begin
            cmd.scan_start = 1'b1;
          end
        end
      end
      frb_pkg::ST_SCAN, frb_pkg::ST_DSCAN: begin
        cmd.scan_step = 1'b1;
      end
      frb_pkg::ST_DECIDE: begin
        if (!status.dup) begin
          if (!status.full) begin
            cmd.store_new = 1'b1;
          end else begin
            cmd.calc_gap = 1'b1;
            cmd.rd_min   = 1'b1;
          end
        end
      end
      frb_pkg::ST_GAP: begin
        cmd.add_gap = 1'b1;
      end
      frb_pkg::ST_FORCE: begin
        if (status.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.emit_cause = frb_pkg::CAUSE_FORCED;
          if (status.new_lt_min) begin
            cmd.emit_src = frb_pkg::SRC_NEW;
          end else begin
            cmd.emit_src     = frb_pkg::SRC_MEM;
            cmd.store_new    = 1'b1;
            cmd.store_at_min = 1'b1;
          end
        end
      end
      frb_pkg::ST_DRAIN: begin
        cmd.scan_start = !status.last_max;
      end
      frb_pkg::ST_DHIT: begin
        if (status.hit_found && status.emit_ok) begin
          cmd.emit       = 1'b1;
          cmd.emit_src   = frb_pkg::SRC_HIT;
          cmd.emit_cause = frb_pkg::CAUSE_DRAINED;
          cmd.clear_hit  = 1'b1;
        end
      end
      frb_pkg::ST_FINISH: begin
        cmd.flush = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/frb_datapath.sv
// ----------------------------------------------------------------------------
// frb_datapath
// Config registers, frame store, search trackers, counters, and the
// pending/output result registers of the reorder buffer.
// ----------------------------------------------------------------------------
module frb_datapath #(
  parameter int STORE_DEPTH  = frb_pkg::STORE_DEPTH_DEF,
  parameter int HANDLE_WIDTH = frb_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [frb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [frb_pkg::CFG_DW-1:0] cfg_data,
  input  logic [frb_pkg::SEQ_W-1:0]  frame_seq,
  input  logic [frb_pkg::LEN_W-1:0]  segment_len,
  input  logic [frb_pkg::LEN_W-1:0]  buffer_len,
  input  logic [HANDLE_WIDTH-1:0]    buffer_handle,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [frb_pkg::SEQ_W-1:0]  out_seq,
  output logic [HANDLE_WIDTH-1:0]    out_handle,
  output logic [frb_pkg::LEN_W-1:0]  payload_len,
  output logic [1:0]                 release_cause,
  output logic                       last_of_run,
  output logic [frb_pkg::CNT_W-1:0]  missed_total,
  output logic [frb_pkg::CNT_W-1:0]  released_total,
  input  frb_pkg::cmd_t              cmd,
  output frb_pkg::status_t           status
);

  localparam int IDXW = $clog2(STORE_DEPTH);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(STORE_DEPTH - 1);

  // configuration
  logic [10:0] min_seg;
  logic [10:0] max_seg;
  logic [10:0] min_buf;
  logic [7:0]  hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_seg <= frb_pkg::MIN_SEG_RST;
      max_seg <= frb_pkg::MAX_SEG_RST;
      min_buf <= frb_pkg::MIN_BUF_RST;
      hdr     <= frb_pkg::HDR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        frb_pkg::CFG_MIN_SEG: min_seg <= cfg_data;
        frb_pkg::CFG_MAX_SEG: max_seg <= cfg_data;
        frb_pkg::CFG_MIN_BUF: min_buf <= cfg_data;
        frb_pkg::CFG_HDR:     hdr     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // captured request
  logic [frb_pkg::SEQ_W-1:0] seq_in;
  logic [frb_pkg::LEN_W-1:0] slen_in;
  logic [frb_pkg::LEN_W-1:0] blen_in;
  logic [HANDLE_WIDTH-1:0]   handle_in;
  logic [frb_pkg::LEN_W-1:0] new_plen;
  logic [frb_pkg::LEN_W-1:0] hdr_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      seq_in    <= frame_seq;
      slen_in   <= segment_len;
      blen_in   <= buffer_len;
      handle_in <= buffer_handle;
    end
  end

  assign hdr_ext  = {8'd0, hdr};
  assign new_plen = (blen_in > hdr_ext) ? (blen_in - hdr_ext) : '0;

  // store
  logic [frb_pkg::SEQ_W-1:0] seq_mem    [STORE_DEPTH];
  logic [HANDLE_WIDTH-1:0]   handle_mem [STORE_DEPTH];
  logic [frb_pkg::LEN_W-1:0] plen_mem   [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]    slot_valid;

  logic [IDXW-1:0]           scan_cnt;
  logic [IDXW-1:0]           rd_addr;
  logic [IDXW-1:0]           wr_addr;
  logic [IDXW-1:0]           rd_idx;
  logic                      rd_live;
  logic                      rd_vld;
  logic [frb_pkg::SEQ_W-1:0] rd_seq;
  logic [HANDLE_WIDTH-1:0]   rd_handle;
  logic [frb_pkg::LEN_W-1:0] rd_plen;

  logic                      dup;
  logic                      min_found;
  logic [frb_pkg::SEQ_W-1:0] min_seq;
  logic [IDXW-1:0]           min_idx;
  logic                      free_found;
  logic [IDXW-1:0]           free_idx;
  logic                      hit_found;
  logic [IDXW-1:0]           hit_idx;
  logic [frb_pkg::SEQ_W-1:0] hit_seq;
  logic [HANDLE_WIDTH-1:0]   hit_handle;
  logic [frb_pkg::LEN_W-1:0] hit_plen;

  logic [frb_pkg::SEQ_W-1:0] last_seq;
  logic [frb_pkg::SEQ_W-1:0] last_p1;

  assign rd_addr = cmd.rd_min ? min_idx : scan_cnt;
  assign wr_addr = cmd.store_at_min ? min_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.store_new) begin
      seq_mem[wr_addr]    <= seq_in;
      handle_mem[wr_addr] <= handle_in;
      plen_mem[wr_addr]   <= new_plen;
    end
    if (cmd.scan_step || cmd.rd_min) begin
      rd_seq    <= seq_mem[rd_addr];
      rd_handle <= handle_mem[rd_addr];
      rd_plen   <= plen_mem[rd_addr];
      rd_vld    <= slot_valid[rd_addr];
      rd_idx    <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (cmd.store_new) slot_valid[wr_addr] <= 1'b1;
      if (cmd.clear_hit) slot_valid[hit_idx] <= 1'b0;
    end
  end

  // one entry per cycle: duplicate, minimum, first free, next-in-order
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt   <= '0;
      rd_live    <= 1'b0;
      dup        <= 1'b0;
      min_found  <= 1'b0;
      free_found <= 1'b0;
      hit_found  <= 1'b0;
      min_seq    <= '0;
      min_idx    <= '0;
      free_idx   <= '0;
      hit_idx    <= '0;
      hit_seq    <= '0;
      hit_handle <= '0;
      hit_plen   <= '0;
    end else if (cmd.scan_start) begin
      scan_cnt   <= '0;
      rd_live    <= 1'b0;
      dup        <= 1'b0;
      min_found  <= 1'b0;
      free_found <= 1'b0;
      hit_found  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_cnt <= (scan_cnt == LAST_IDX) ? '0 : scan_cnt + 1'b1;
      rd_live  <= 1'b1;
      if (rd_live) begin
        if (rd_vld) begin
          if (rd_seq == seq_in) dup <= 1'b1;
          if (!min_found || (rd_seq < min_seq)) begin
            min_found <= 1'b1;
            min_seq   <= rd_seq;
            min_idx   <= rd_idx;
          end
          if (rd_seq == last_p1) begin
            hit_found  <= 1'b1;
            hit_idx    <= rd_idx;
            hit_seq    <= rd_seq;
            hit_handle <= rd_handle;
            hit_plen   <= rd_plen;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  // counters and release bookkeeping
  logic                      any_released;
  logic [frb_pkg::CNT_W-1:0] missed;
  logic [frb_pkg::CNT_W-1:0] released;
  logic [frb_pkg::CNT_W-1:0] released_next;
  logic [frb_pkg::CNT_W-1:0] gap;
  logic [frb_pkg::CNT_W:0]   missed_sum;

  logic [frb_pkg::SEQ_W-1:0] e_seq;
  logic [HANDLE_WIDTH-1:0]   e_handle;
  logic [frb_pkg::LEN_W-1:0] e_plen;

  logic                      pend_valid;
  logic [frb_pkg::SEQ_W-1:0] pend_seq;
  logic [HANDLE_WIDTH-1:0]   pend_handle;
  logic [frb_pkg::LEN_W-1:0] pend_plen;
  logic [1:0]                pend_cause;
  logic [frb_pkg::CNT_W-1:0] pend_missed;
  logic [frb_pkg::CNT_W-1:0] pend_released;
  logic                      push_out;

  always_comb begin
    case (cmd.emit_src)
      frb_pkg::SRC_MEM: begin
        e_seq    = rd_seq;
        e_handle = rd_handle;
        e_plen   = rd_plen;
      end
      frb_pkg::SRC_HIT: begin
        e_seq    = hit_seq;
        e_handle = hit_handle;
        e_plen   = hit_plen;
      end
      default: begin
        e_seq    = seq_in;
        e_handle = handle_in;
        e_plen   = new_plen;
      end
    endcase
  end

  assign released_next = (&released) ? released : released + 1'b1;
  assign missed_sum    = {1'b0, missed} + {1'b0, gap};
  assign push_out      = (cmd.emit && pend_valid) || cmd.flush;

  // seq - (last + 1) == seq + ~last
  always_ff @(posedge clk) begin
    if (cmd.calc_gap) begin
      gap <= (status.new_lt_min ? seq_in : min_seq) + ~last_seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq     <= '0;
      last_p1      <= 32'd1;
      any_released <= 1'b0;
      missed       <= '0;
      released     <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.add_gap) begin
        missed <= missed_sum[frb_pkg::CNT_W] ? '1 : missed_sum[frb_pkg::CNT_W-1:0];
      end
      if (cmd.emit) begin
        last_seq     <= e_seq;
        last_p1      <= e_seq + 1'b1;
        any_released <= 1'b1;
        released     <= released_next;
        pend_valid   <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_seq      <= e_seq;
      pend_handle   <= e_handle;
      pend_plen     <= e_plen;
      pend_cause    <= cmd.emit_cause;
      pend_missed   <= missed;
      pend_released <= released_next;
    end
    if (push_out) begin
      out_seq        <= pend_seq;
      out_handle     <= pend_handle;
      payload_len    <= pend_plen;
      release_cause  <= pend_cause;
      missed_total   <= pend_missed;
      released_total <= pend_released;
      last_of_run    <= cmd.flush;
    end
  end

  always_comb begin
    status            = '0;
    status.bad_len    = ({5'd0, min_seg} > slen_in) || (slen_in > {5'd0, max_seg})
                        || (blen_in < {5'd0, min_buf});
    status.first      = !any_released;
    status.stale      = (seq_in <= last_seq);
    status.next       = (seq_in == last_p1);
    status.last_max   = &last_seq;
    status.scan_last  = rd_live && (rd_idx == LAST_IDX);
    status.dup        = dup;
    status.full       = &slot_valid;
    status.new_lt_min = (seq_in < min_seq);
    status.hit_found  = hit_found;
    status.out_free   = !out_valid || !out_stall;
    status.emit_ok    = !pend_valid || status.out_free;
  end

endmodule

FILE: rtl/core/frb_checker.sv
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks for the frame reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
module frb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [frb_pkg::SEQ_W-1:0] out_seq,
  input logic [1:0]                release_cause,
  input logic                      last_of_run,
  input logic [frb_pkg::CNT_W-1:0] missed_total,
  input logic [frb_pkg::CNT_W-1:0] released_total
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_seq) && $stable(last_of_run))
    else $error("stalled release changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_released_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> released_total != '0)
    else $error("release with zero released count");

  a_forced_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (release_cause == frb_pkg::CAUSE_FORCED) |-> missed_total != '0)
    else $error("forced release without missed frames");

endmodule

bind frame_reorder_buffer frb_checker u_frb_checker (.*);
